// ----- sv/ultrasonic_range_median_macros.svh -----
// Assertion macros shared by the checker of the ultrasonic range block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ULTRASONIC_RANGE_MEDIAN_MACROS_SVH
`define ULTRASONIC_RANGE_MEDIAN_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define URM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urm checker: same-cycle property failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define URM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urm checker: next-cycle property failed");

`endif

// ----- sv/urm_pkg.sv -----
// Package for the ultrasonic range block: widths, reset values, register
// indexes, the sequencer phase type and the per-item flag struct. No dependencies.
`default_nettype none

package urm_pkg;

    localparam int SAMPLE_COUNT_DEF = 5;

    localparam int WAIT_W   = 20;
    localparam int WIDTH_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [WAIT_W-1:0]  TIMEOUT_RST     = 20'd500000;
    localparam logic [WIDTH_W-1:0] GAIN_RST        = 16'd256;
    localparam logic [WIDTH_W-1:0] OFFSET_RST      = 16'd0;
    localparam logic [WAIT_W-1:0]  TRIG_LOW_TICKS  = 20'd2;
    localparam logic [WAIT_W-1:0]  TRIG_HIGH_TICKS = 20'd10;
    localparam logic [WAIT_W-1:0]  WAIT_MAX        = 20'hFFFFF;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX       = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TLOW,
        PH_THIGH,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    // Flags that travel with an item down the result pipeline.
    typedef struct packed {
        logic trigger;
        logic busy;
        logic done;
        logic timed_out;
        logic calc;
    } flags_t;

endpackage

`default_nettype wire

// ----- sv/ultrasonic_range_median.sv -----
// Top level of the ultrasonic ranging block with median filter: configuration
// registers and the four-stage result pipeline. Depends on urm_pkg, urm_ctrl,
// urm_median and urm_calib.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   config  | cfg_we, cfg_index, cfg_data              | in
//   input   | in_valid/in_ready, start_req, echo       | in
//   result  | out_valid/out_ready, trigger, busy_res,  | out
//           | done_res, timed_out, distance            |
//
// One item is accepted per cycle while no output stall holds the pipeline; its result
// is registered through stage one to stage four in turn before it shows at the outputs.
// The sequencer step is stage one, the median rank select stage two, the gain
// multiply stage three and the offset add with saturation stage four.
// Every stage holds under an output stall and frees as soon as the one after it moves.
// Reset clears the sequencer and the stage valid bits and loads the configuration registers with their reset values.
`default_nettype none

module ultrasonic_range_median
    import urm_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  start_req,
    input  logic                  echo,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  trigger,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  timed_out,
    output logic [WIDTH_W-1:0]    distance
);

    logic [WAIT_W-1:0]  timeout_reg;
    logic [WIDTH_W-1:0] offset_reg;
    logic [WIDTH_W-1:0] gain_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy2, rdy3, rdy4;
    logic en1, en2, en3, en4;

    flags_t             flags1, flags2, flags4;
    logic [WIDTH_W-1:0] samples [SAMPLE_COUNT];
    logic [WIDTH_W-1:0] median2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            offset_reg  <= OFFSET_RST;
            gain_reg    <= GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                CFG_OFFSET:  offset_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_GAIN:    gain_reg    <= cfg_data[WIDTH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Stage handshake: a stage can load when it is empty or its item moves on.
    always_comb
    begin
        rdy4     = !v4_reg || out_ready;
        rdy3     = !v3_reg || rdy4;
        rdy2     = !v2_reg || rdy3;
        in_ready = !v1_reg || rdy2;
        en1      = in_valid && in_ready;
        en2      = v1_reg && rdy2;
        en3      = v2_reg && rdy3;
        en4      = v3_reg && rdy4;
        v1_next  = en1 || (v1_reg && !en2);
        v2_next  = en2 || (v2_reg && !en3);
        v3_next  = en3 || (v3_reg && !en4);
        v4_next  = en4 || (v4_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    urm_ctrl #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (en1),
        .start_req   (start_req),
        .echo        (echo),
        .timeout     (timeout_reg),
        .flags_reg   (flags1),
        .samples_reg (samples)
    );

    // The sample store is stable while a finishing item waits in stage one,
    // since no new item is taken until that item moves on.
    urm_median #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_median (
        .clk        (clk),
        .load       (en2),
        .flags_in   (flags1),
        .samples    (samples),
        .flags_reg  (flags2),
        .median_reg (median2)
    );

    urm_calib u_calib (
        .clk          (clk),
        .load_mul     (en3),
        .load_sum     (en4),
        .flags_in     (flags2),
        .median       (median2),
        .gain         (gain_reg),
        .offset       (offset_reg),
        .flags_reg    (flags4),
        .distance_reg (distance)
    );

    assign out_valid = v4_reg;
    assign trigger   = flags4.trigger;
    assign busy_res  = flags4.busy;
    assign done_res  = flags4.done;
    assign timed_out = flags4.timed_out;

endmodule

`default_nettype wire

// ----- sv/urm_ctrl.sv -----
// Measurement sequencer: trigger timing, echo wait and width count, timeout,
// and the sample store. Depends on urm_pkg.
`default_nettype none

module urm_ctrl
    import urm_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1)
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                start_req,
    input  logic                echo,
    input  logic [WAIT_W-1:0]   timeout,
    output flags_t              flags_reg,
    output logic [WIDTH_W-1:0]  samples_reg [SAMPLE_COUNT]
);

    phase_t              phase_reg, phase_next, ph_cur;
    logic [WAIT_W-1:0]   wait_reg, wait_next, wait_cur, wait_inc;
    logic [WIDTH_W-1:0]  width_reg, width_next, width_cur;
    logic [CNT_W-1:0]    attempt_reg, attempt_next, attempt_cur, attempt_inc;
    logic                start_now;
    logic                pulse_end;
    logic                last_attempt;
    logic                hit_timeout;
    flags_t              flags_next;

    // A start request in idle makes this tick the first trigger-low tick.
    always_comb
    begin
        start_now    = (phase_reg == PH_IDLE) && start_req;
        ph_cur       = start_now ? PH_TLOW : phase_reg;
        wait_cur     = start_now ? '0 : wait_reg;
        width_cur    = start_now ? '0 : width_reg;
        attempt_cur  = start_now ? '0 : attempt_reg;
        attempt_inc  = attempt_cur + 1'b1;
        last_attempt = attempt_inc >= CNT_W'(SAMPLE_COUNT);
        if ((ph_cur == PH_WAIT || ph_cur == PH_MEAS) && wait_cur == WAIT_MAX)
        begin
            wait_inc = wait_cur;
        end
        else
        begin
            wait_inc = wait_cur + 1'b1;
        end
        pulse_end   = (ph_cur == PH_MEAS) && !echo;
        hit_timeout = (ph_cur == PH_WAIT || ph_cur == PH_MEAS) && !pulse_end
                      && (wait_inc >= timeout);
    end

    // Next state and counters.
    always_comb
    begin
        phase_next   = ph_cur;
        wait_next    = wait_cur;
        width_next   = width_cur;
        attempt_next = attempt_cur;
        case (ph_cur)
            PH_IDLE:
            begin
            end
            PH_TLOW:
            begin
                wait_next = wait_inc;
                if (wait_inc >= TRIG_LOW_TICKS)
                begin
                    phase_next = PH_THIGH;
                    wait_next  = '0;
                end
            end
            PH_THIGH:
            begin
                wait_next = wait_inc;
                if (wait_inc >= TRIG_HIGH_TICKS)
                begin
                    phase_next = PH_WAIT;
                    wait_next  = '0;
                    width_next = '0;
                end
            end
            PH_WAIT, PH_MEAS:
            begin
                wait_next = wait_inc;
                if (ph_cur == PH_WAIT && echo)
                begin
                    width_next = WIDTH_W'(1);
                    phase_next = PH_MEAS;
                end
                else if (ph_cur == PH_MEAS && echo && width_cur != WIDTH_MAX)
                begin
                    width_next = width_cur + 1'b1;
                end
                if (pulse_end)
                begin
                    attempt_next = attempt_inc;
                    if (last_attempt)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_TLOW;
                        wait_next  = '0;
                        width_next = '0;
                    end
                end
                else if (hit_timeout)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Per-item output flags.
    always_comb
    begin
        flags_next.trigger   = (ph_cur == PH_THIGH);
        flags_next.busy      = (ph_cur != PH_IDLE);
        flags_next.calc      = pulse_end && last_attempt;
        flags_next.timed_out = hit_timeout;
        flags_next.done      = (pulse_end && last_attempt) || hit_timeout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            wait_reg    <= '0;
            width_reg   <= '0;
            attempt_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            wait_reg    <= wait_next;
            width_reg   <= width_next;
            attempt_reg <= attempt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags_next;
        end
    end

    // The ending pulse width goes into the slot of the current attempt.
    for (genvar k = 0; k < SAMPLE_COUNT; k++)
    begin : g_sample
        always_ff @(posedge clk)
        begin
            if (accept && pulse_end && attempt_cur == CNT_W'(k))
            begin
                samples_reg[k] <= width_cur;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/urm_median.sv -----
// Median stage: ranks every stored sample against the others in parallel and
// registers the one of middle rank. Depends on urm_pkg.
`default_nettype none

module urm_median
    import urm_pkg::*;
#(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
    localparam int CNT_W = $clog2(SAMPLE_COUNT + 1),
    localparam int MID   = (SAMPLE_COUNT - 1) / 2
)(
    input  logic                clk,
    input  logic                load,
    input  flags_t              flags_in,
    input  logic [WIDTH_W-1:0]  samples [SAMPLE_COUNT],
    output flags_t              flags_reg,
    output logic [WIDTH_W-1:0]  median_reg
);

    logic [CNT_W-1:0]   rank [SAMPLE_COUNT];
    logic [WIDTH_W-1:0] median_next;

    // Equal values are ordered by slot, so every rank is distinct and exactly
    // one sample holds the lower-middle rank.
    always_comb
    begin
        median_next = '0;
        for (int i = 0; i < SAMPLE_COUNT; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < SAMPLE_COUNT; j++)
            begin
                if (j != i && (samples[j] < samples[i]
                               || (samples[j] == samples[i] && j < i)))
                begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
            if (rank[i] == CNT_W'(MID))
            begin
                median_next = median_next | samples[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg  <= flags_in;
            median_reg <= median_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/urm_calib.sv -----
// Calibration stages: Q8.8 gain product in one stage, then offset add with
// saturation to 16 bits in the next. Depends on urm_pkg.
`default_nettype none

module urm_calib
    import urm_pkg::*;
(
    input  logic                clk,
    input  logic                load_mul,
    input  logic                load_sum,
    input  flags_t              flags_in,
    input  logic [WIDTH_W-1:0]  median,
    input  logic [WIDTH_W-1:0]  gain,
    input  logic [WIDTH_W-1:0]  offset,
    output flags_t              flags_reg,
    output logic [WIDTH_W-1:0]  distance_reg
);

    flags_t                  mul_flags_reg;
    logic [2*WIDTH_W-9:0]    scaled_reg;
    logic [2*WIDTH_W-1:0]    product;
    logic signed [2*WIDTH_W-7:0] sum;
    logic [WIDTH_W-1:0]      sat;

    assign product = {{WIDTH_W{1'b0}}, gain} * {{WIDTH_W{1'b0}}, median};

    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            mul_flags_reg <= flags_in;
            scaled_reg    <= product[2*WIDTH_W-1:8];
        end
    end

    // The scaled value is at most 24 bits, so a 26-bit signed sum cannot overflow.
    always_comb
    begin
        sum = $signed({2'b00, scaled_reg})
              + $signed({{(WIDTH_W-6){offset[WIDTH_W-1]}}, offset});
        if (sum[2*WIDTH_W-7])
        begin
            sat = '0;
        end
        else if (sum[2*WIDTH_W-8:WIDTH_W] != '0)
        begin
            sat = WIDTH_MAX;
        end
        else
        begin
            sat = sum[WIDTH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            flags_reg    <= mul_flags_reg;
            distance_reg <= mul_flags_reg.calc ? sat : '0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/urm_checker.sv -----
// Port-level checker for the ultrasonic range block and its bind statement.
// Depends on urm_pkg and ultrasonic_range_median_macros.svh.
`default_nettype none

`include "ultrasonic_range_median_macros.svh"

module urm_checker
    import urm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic               trigger,
    input  wire logic               busy_res,
    input  wire logic               done_res,
    input  wire logic               timed_out,
    input  wire logic [WIDTH_W-1:0] distance
);

    // A stalled result keeps its whole payload.
    `URM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(distance) && $stable(done_res) && $stable(timed_out) && $stable(trigger) && $stable(busy_res))

    // Distance is only nonzero on the item that finishes a run.
    `URM_ASSERT_NOW(a_dist_only_done, out_valid && !done_res, distance == '0)

    // A timeout finishes a run inside it and reports no distance.
    `URM_ASSERT_NOW(a_timeout_form, out_valid && timed_out, done_res && busy_res && distance == '0)

    // The trigger pulse never coincides with the end of a run.
    `URM_ASSERT_NOW(a_trigger_in_run, out_valid && trigger, busy_res && !done_res)

endmodule

bind ultrasonic_range_median urm_checker u_urm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .trigger   (trigger),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .timed_out (timed_out),
    .distance  (distance)
);

`default_nettype wire
